>>> rtl/mfbf_pkg.sv
package mfbf_pkg;

    // Field widths of the stream payloads.
    localparam int MODE_W      = 3;
    localparam int DATA_W      = 8;
    localparam int HELD_W      = 11;
    localparam int STATUS_W    = 2;
    localparam int M_TDATA_W   = 24;

    // Bits in one byte transfer and the last step of a byte sequence.
    localparam int BYTE_BITS   = 8;
    localparam logic [2:0] BYTE_LAST = 3'd7;

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Operation codes carried in s_tuser.
    localparam mode_t MODE_APPEND_BIT  = 3'd0;
    localparam mode_t MODE_APPEND_BYTE = 3'd1;
    localparam mode_t MODE_POP_BYTE    = 3'd2;
    localparam mode_t MODE_POP_BIT     = 3'd3;
    localparam mode_t MODE_DROP_BIT    = 3'd4;

    // Result status codes carried in m_tuser.
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_OVERFLOW  = 2'd1;
    localparam status_t ST_UNDERFLOW = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    ready;
        logic    push;
        logic    pop;
        logic    drop;
        logic    load_result;
        status_t status;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic  in_valid;
        mode_t mode;
        logic  room_bit;
        logic  room_byte;
        logic  have_bit;
        logic  have_byte;
        logic  out_free;
    } dp_stat_t;

endpackage

>>> rtl/msb_first_bit_fifo.sv
// Bit-granular FIFO that packs bits MSB-first in a circular store of
// CAPACITY_BITS one-bit entries. Each s_ transfer carries an operation in
// s_tuser (append bit, append byte, pop byte, pop bit, drop last bit) and
// returns exactly one m_ transfer with the popped data, the bit count after
// the operation and a status (ok, overflow refused, underflow refused).
// The store has a single write port and a single read port and moves one
// bit per cycle. After acceptance an operation is decoded, its bits are
// moved, a pop takes one extra step for the registered read, and the
// result is loaded into the output register; a drop, a refused or an
// unknown operation moves no bits. The block takes no new transfer until
// the result is loaded, and the next transfer is taken in the cycle after
// the load. A finished result waits in the output register while the next
// transfer is accepted; if an earlier result is still waiting there, the
// load and the next acceptance are held off until it is taken. The store
// needs no clearing after reset.
module msb_first_bit_fifo #(
    parameter int CAPACITY_BITS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_in
    input  logic [2:0]  s_tuser,   // [2:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_out, [18:8] bits_held, [23:19] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    mfbf_pkg::dp_cmd_t  cmd;
    mfbf_pkg::dp_stat_t stat;

    // Sequencer for the bit moves of each operation.
    mfbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Store, pointers, shifters and the output register.
    mfbf_datapath #(
        .CAPACITY_BITS (CAPACITY_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

>>> rtl/mfbf_ram.sv
module mfbf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/mfbf_datapath.sv
module mfbf_datapath #(
    parameter int CAPACITY_BITS = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mfbf_pkg::DATA_W-1:0]   s_tdata,
    input  logic [mfbf_pkg::MODE_W-1:0]   s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mfbf_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [mfbf_pkg::STATUS_W-1:0] m_tuser,
    input  mfbf_pkg::dp_cmd_t             cmd,
    output mfbf_pkg::dp_stat_t            stat
);

    localparam int IDX_W = $clog2(CAPACITY_BITS);
    localparam int CNT_W = $clog2(CAPACITY_BITS + 1);
    localparam int DW    = mfbf_pkg::DATA_W;
    localparam int HW    = mfbf_pkg::HELD_W;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(CAPACITY_BITS - 1);
    localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(CAPACITY_BITS);
    localparam logic [CNT_W-1:0] BYTE_ROOM = CNT_W'(CAPACITY_BITS - mfbf_pkg::BYTE_BITS);
    localparam logic [CNT_W-1:0] BYTE_CNT  = CNT_W'(mfbf_pkg::BYTE_BITS);

    logic [IDX_W-1:0]       head_reg, head_next;
    logic [IDX_W-1:0]       tail_reg, tail_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    mfbf_pkg::mode_t        mode_reg;
    logic [DW-1:0]          shift_reg;
    logic [DW-1:0]          dout_reg;
    logic                   rd_pend_reg;
    logic                   m_tvalid_reg;
    logic [DW-1:0]          m_dout_reg;
    logic [HW-1:0]          m_held_reg;
    mfbf_pkg::status_t      m_status_reg;
    logic                   capture;
    logic                   rd_bit;
    logic [CNT_W+HW-1:0]    held_ext;

    assign capture  = s_tvalid && cmd.ready;
    assign s_tready = cmd.ready;

    // Queue occupancy flags, input valid, captured mode and output-free flag for the controller.
    assign stat.in_valid  = s_tvalid;
    assign stat.mode      = mode_reg;
    assign stat.room_bit  = (count_reg < CAP_CNT);
    assign stat.room_byte = (count_reg <= BYTE_ROOM);
    assign stat.have_bit  = (count_reg != '0);
    assign stat.have_byte = (count_reg >= BYTE_CNT);
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    // Head, tail and count follow the push, pop and drop commands.
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.push) begin
            tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end else if (cmd.pop) begin
            head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end else if (cmd.drop) begin
            tail_next  = (tail_reg == '0) ? LAST_IDX : tail_reg - 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            rd_pend_reg <= cmd.pop;
        end
    end

    // Operand capture, the write shifter and the read collector.
    always_ff @(posedge aclk) begin
        if (capture) begin
            mode_reg <= s_tuser;
            if (s_tuser == mfbf_pkg::MODE_APPEND_BIT) begin
                shift_reg <= {s_tdata[0], {(DW-1){1'b0}}};
            end else begin
                shift_reg <= s_tdata;
            end
            dout_reg <= '0;
        end else begin
            if (cmd.push) begin
                shift_reg <= {shift_reg[DW-2:0], 1'b0};
            end
            if (rd_pend_reg) begin
                dout_reg <= {dout_reg[DW-2:0], rd_bit};
            end
        end
    end

    mfbf_ram #(
        .WIDTH (1),
        .DEPTH (CAPACITY_BITS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (cmd.push),
        .wr_addr (tail_reg),
        .wr_data (shift_reg[DW-1]),
        .rd_en   (cmd.pop),
        .rd_addr (head_reg),
        .rd_data (rd_bit)
    );

    // Output register; the count is cut to the width of the field.
    assign held_ext = {{HW{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_result) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            m_dout_reg   <= dout_reg;
            m_held_reg   <= held_ext[HW-1:0];
            m_status_reg <= cmd.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(mfbf_pkg::M_TDATA_W-DW-HW){1'b0}}, m_held_reg, m_dout_reg};
    assign m_tuser  = m_status_reg;

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("bit count exceeds capacity");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> count_reg != CAP_CNT)
        else $error("push into a full store");

    a_no_take_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pop || cmd.drop) |-> count_reg != '0)
        else $error("pop or drop from an empty store");

    a_count_idle_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (!cmd.push && !cmd.pop && !cmd.drop) |=> $stable(count_reg))
        else $error("bit count changed without a command");

    a_result_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over a pending transfer");
`endif

endmodule

>>> rtl/mfbf_ctrl.sv
module mfbf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  mfbf_pkg::dp_stat_t stat,
    output mfbf_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PUSH,
        S_POP,
        S_DRAIN,
        S_RESULT
    } state_t;

    state_t            state_reg, state_next;
    logic [2:0]        steps_reg, steps_next;
    mfbf_pkg::status_t status_reg, status_next;

    // Next state, step counter and result status.
    always_comb begin
        state_next  = state_reg;
        steps_next  = steps_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (stat.in_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                status_next = mfbf_pkg::ST_OK;
                state_next  = S_RESULT;
                case (stat.mode)
                    mfbf_pkg::MODE_APPEND_BIT: begin
                        if (stat.room_bit) begin
                            state_next = S_PUSH;
                            steps_next = '0;
                        end else begin
                            status_next = mfbf_pkg::ST_OVERFLOW;
                        end
                    end
                    mfbf_pkg::MODE_APPEND_BYTE: begin
                        if (stat.room_byte) begin
                            state_next = S_PUSH;
                            steps_next = mfbf_pkg::BYTE_LAST;
                        end else begin
                            status_next = mfbf_pkg::ST_OVERFLOW;
                        end
                    end
                    mfbf_pkg::MODE_POP_BYTE: begin
                        if (stat.have_byte) begin
                            state_next = S_POP;
                            steps_next = mfbf_pkg::BYTE_LAST;
                        end else begin
                            status_next = mfbf_pkg::ST_UNDERFLOW;
                        end
                    end
                    mfbf_pkg::MODE_POP_BIT: begin
                        if (stat.have_bit) begin
                            state_next = S_POP;
                            steps_next = '0;
                        end else begin
                            status_next = mfbf_pkg::ST_UNDERFLOW;
                        end
                    end
                    mfbf_pkg::MODE_DROP_BIT: begin
                        if (!stat.have_bit) begin
                            status_next = mfbf_pkg::ST_UNDERFLOW;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_PUSH: begin
                if (steps_reg == '0) begin
                    state_next = S_RESULT;
                end else begin
                    steps_next = steps_reg - 1'b1;
                end
            end
            S_POP: begin
                if (steps_reg == '0) begin
                    state_next = S_DRAIN;
                end else begin
                    steps_next = steps_reg - 1'b1;
                end
            end
            S_DRAIN: begin
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            steps_reg  <= '0;
            status_reg <= mfbf_pkg::ST_OK;
        end else begin
            state_reg  <= state_next;
            steps_reg  <= steps_next;
            status_reg <= status_next;
        end
    end

    // Commands decoded from the current state.
    always_comb begin
        cmd.ready       = (state_reg == S_IDLE);
        cmd.push        = (state_reg == S_PUSH);
        cmd.pop         = (state_reg == S_POP);
        cmd.drop        = (state_reg == S_DECODE) &&
                          (stat.mode == mfbf_pkg::MODE_DROP_BIT) && stat.have_bit;
        cmd.load_result = (state_reg == S_RESULT) && stat.out_free;
        cmd.status      = status_reg;
    end

`ifndef SYNTHESIS
    a_push_follows_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DECODE && state_next == S_PUSH) |-> stat.room_bit)
        else $error("append started without room");

    a_drain_after_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DRAIN) |-> $past(state_reg) == S_POP)
        else $error("drain entered without a pop");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.ready && stat.in_valid) |=> state_reg == S_DECODE)
        else $error("accepted transfer not decoded");
`endif

endmodule

>>> tb/sv/msb_first_bit_fifo_checker.sv
// Watches both stream channels of the bit FIFO. Every accepted input transfer
// is run through a shadow copy of the queue, and the result it should give is
// kept in order. Every accepted result transfer is compared field by field
// with the oldest of those results.
module msb_first_bit_fifo_checker
    import mfbf_pkg::*;
#(
    parameter int CAPACITY_BITS = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,    // [7:0] data_in
    input  logic [MODE_W-1:0]    s_tuser,    // [2:0] mode
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,    // [7:0] data_out, [18:8] bits_held, [23:19] zero
    input  logic [STATUS_W-1:0]  m_tuser,    // [1:0] status
    output int                   fail_count,
    output int                   results_due,
    output int                   results_seen
);

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic [HELD_W-1:0] bits_held;
        status_t           status;
    } fifo_result_t;

    // Shadow copy of the queue: circular bit store, head, tail and fill level.
    logic shadow_bits [CAPACITY_BITS];
    int   shadow_head;
    int   shadow_tail;
    int   shadow_fill;

    // Results owed by the block, oldest first.
    fifo_result_t owed_results [$];

    task automatic note_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic void push_tail_bit(input logic b);
        shadow_bits[shadow_tail] = b;
        shadow_tail = (shadow_tail + 1) % CAPACITY_BITS;
        shadow_fill++;
    endfunction

    function automatic logic take_head_bit();
        logic b;
        b = shadow_bits[shadow_head];
        shadow_head = (shadow_head + 1) % CAPACITY_BITS;
        shadow_fill--;
        return b;
    endfunction

    // Applies one operation to the shadow queue and returns the result it gives.
    function automatic fifo_result_t apply_fifo_op(input mode_t op,
                                                   input logic [DATA_W-1:0] din);
        fifo_result_t r;
        r = '0;
        r.status = ST_OK;
        case (op)
            MODE_APPEND_BIT: begin
                if (shadow_fill + 1 > CAPACITY_BITS) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    push_tail_bit(din[0]);
                end
            end
            MODE_APPEND_BYTE: begin
                // A byte that does not fit is refused whole; otherwise bit 7 goes first.
                if (shadow_fill + BYTE_BITS > CAPACITY_BITS) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    for (int i = BYTE_BITS - 1; i >= 0; i--) begin
                        push_tail_bit(din[i]);
                    end
                end
            end
            MODE_POP_BYTE: begin
                // The first bit taken ends up in bit 7.
                if (shadow_fill < BYTE_BITS) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    for (int i = 0; i < BYTE_BITS; i++) begin
                        r.data_out = {r.data_out[DATA_W-2:0], take_head_bit()};
                    end
                end
            end
            MODE_POP_BIT: begin
                if (shadow_fill < 1) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    r.data_out = {{(DATA_W-1){1'b0}}, take_head_bit()};
                end
            end
            MODE_DROP_BIT: begin
                if (shadow_fill < 1) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    shadow_tail = (shadow_tail + CAPACITY_BITS - 1) % CAPACITY_BITS;
                    shadow_fill--;
                end
            end
            default: begin
                // Unused modes leave the queue alone.
            end
        endcase
        r.bits_held = HELD_W'(shadow_fill);
        return r;
    endfunction

    // Results are checked before the input of the same edge is predicted, since
    // a result can never belong to an operation accepted at that very edge.
    always @(posedge aclk) begin : watch
        fifo_result_t got;
        fifo_result_t want;
        if (!aresetn) begin
            owed_results.delete();
            shadow_head = 0;
            shadow_tail = 0;
            shadow_fill = 0;
            fail_count = 0;
            results_seen <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.data_out  = m_tdata[DATA_W-1:0];
                got.bits_held = m_tdata[DATA_W +: HELD_W];
                got.status    = m_tuser;
                results_seen <= results_seen + 1;
                if (m_tdata[M_TDATA_W-1:DATA_W+HELD_W] != '0) begin
                    note_mismatch($sformatf("padding bits of m_tdata are %0h",
                                            m_tdata[M_TDATA_W-1:DATA_W+HELD_W]));
                end
                if (owed_results.size() == 0) begin
                    note_mismatch($sformatf("result transfer with none outstanding: %0h/%0d/%0d",
                                            got.data_out, got.bits_held, got.status));
                end else begin
                    want = owed_results.pop_front();
                    if (got.data_out != want.data_out) begin
                        note_mismatch($sformatf("data_out %0h, expected %0h",
                                                got.data_out, want.data_out));
                    end
                    if (got.bits_held != want.bits_held) begin
                        note_mismatch($sformatf("bits_held %0d, expected %0d",
                                                got.bits_held, want.bits_held));
                    end
                    if (got.status != want.status) begin
                        note_mismatch($sformatf("status %0d, expected %0d",
                                                got.status, want.status));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                owed_results.push_back(apply_fifo_op(s_tuser, s_tdata));
            end
        end
        results_due <= owed_results.size();
    end

endmodule

>>> tb/sv/msb_first_bit_fifo_test.sv
// Stimulus and verdict for the MSB-first bit FIFO. Checking is done by the
// checker instance beside the block.
module msb_first_bit_fifo_test;
    import mfbf_pkg::*;

    localparam int    CAPACITY_BITS = 1024;
    localparam int    CYCLE_LIMIT   = 200000;
    localparam int    SETTLE_CYCLES = 20;
    localparam int    MAX_IDLE      = 14;
    localparam mode_t MODE_TOP      = '1;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata  = '0;
    logic [MODE_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    // Set for the closing stretch, where neither side idles.
    logic quiet       = 1'b0;
    int   ready_hold  = 0;
    int   cycle_count = 0;
    int   ops_sent    = 0;
    int   fail_count;
    int   results_due;
    int   results_seen;

    always #5 aclk = ~aclk;

    msb_first_bit_fifo #(
        .CAPACITY_BITS(CAPACITY_BITS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    msb_first_bit_fifo_checker #(
        .CAPACITY_BITS(CAPACITY_BITS)
    ) results_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .results_due (results_due),
        .results_seen(results_seen)
    );

    // Result side: ready and stall in random bursts until the quiet stretch.
    always @(posedge aclk) begin
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_tready   <= ($urandom_range(0, 2) != 0);
            ready_hold <= $urandom_range(1, MAX_IDLE);
        end
    end

    // Stop a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("msb_first_bit_fifo test failed");
            $finish;
        end
    end

    // One input transfer, sometimes preceded by an idle burst.
    task automatic send_op(input mode_t op, input logic [DATA_W-1:0] din);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, MAX_IDLE)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= din;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ops_sent++;
    endtask

    // Hold the input side until every outstanding result has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
    endtask

    // A mostly well-formed mix that drifts slowly upward in fill level.
    task automatic send_random_op();
        int    pick;
        mode_t op;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            op = MODE_APPEND_BIT;
        end else if (pick < 45) begin
            op = MODE_APPEND_BYTE;
        end else if (pick < 65) begin
            op = MODE_POP_BYTE;
        end else if (pick < 82) begin
            op = MODE_POP_BIT;
        end else if (pick < 95) begin
            op = MODE_DROP_BIT;
        end else begin
            op = mode_t'($urandom_range(int'(MODE_DROP_BIT) + 1, int'(MODE_TOP)));
        end
        send_op(op, DATA_W'($urandom()));
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Refusals on an empty queue and the unused modes.
        send_op(MODE_POP_BIT, 8'h00);
        send_op(MODE_DROP_BIT, 8'hFF);
        send_op(MODE_POP_BYTE, 8'h00);
        send_op(MODE_DROP_BIT + 3'd1, 8'hFF);
        send_op(MODE_DROP_BIT + 3'd2, 8'h00);
        send_op(MODE_TOP, 8'hA5);

        // Append bit uses bit 0 only; then byte extremes.
        send_op(MODE_APPEND_BIT, 8'hFE);
        send_op(MODE_APPEND_BIT, 8'h01);
        send_op(MODE_APPEND_BYTE, 8'hFF);
        send_op(MODE_APPEND_BYTE, 8'h00);
        send_op(MODE_POP_BYTE, 8'hFF);
        send_op(MODE_DROP_BIT, 8'h00);
        send_op(MODE_POP_BYTE, 8'h00);

        // A byte pop with one bit left is refused, then drain to empty.
        send_op(MODE_POP_BYTE, 8'hFF);
        send_op(MODE_POP_BIT, 8'h00);
        send_op(MODE_POP_BIT, 8'hFF);

        // Bit order across byte boundaries.
        send_op(MODE_APPEND_BYTE, 8'h80);
        send_op(MODE_APPEND_BYTE, 8'h01);
        send_op(MODE_POP_BIT, 8'h00);
        send_op(MODE_POP_BYTE, 8'h00);
        send_op(MODE_DROP_BIT, 8'h00);
        send_op(MODE_POP_BYTE, 8'h00);
        send_op(MODE_TOP, 8'h5A);

        repeat (230) send_random_op();
        wait_for_results();

        // Fill to capacity, probing both overflow refusals on the way.
        repeat (CAPACITY_BITS / BYTE_BITS - 1) send_op(MODE_APPEND_BYTE, DATA_W'($urandom()));
        repeat (4) send_op(MODE_APPEND_BIT, DATA_W'($urandom()));
        send_op(MODE_APPEND_BYTE, DATA_W'($urandom()));
        repeat (4) send_op(MODE_APPEND_BIT, DATA_W'($urandom()));
        send_op(MODE_APPEND_BIT, DATA_W'($urandom()));
        send_op(MODE_APPEND_BYTE, DATA_W'($urandom()));
        send_op(MODE_TOP, DATA_W'($urandom()));
        send_op(MODE_DROP_BIT, DATA_W'($urandom()));
        send_op(MODE_APPEND_BYTE, DATA_W'($urandom()));
        send_op(MODE_APPEND_BIT, DATA_W'($urandom()));

        // Churn right at the full mark.
        repeat (20) begin
            case ($urandom_range(0, 3))
                0: send_op(MODE_DROP_BIT, DATA_W'($urandom()));
                1: send_op(MODE_APPEND_BIT, DATA_W'($urandom()));
                2: send_op(MODE_APPEND_BYTE, DATA_W'($urandom()));
                default: send_op(MODE_POP_BIT, DATA_W'($urandom()));
            endcase
        end

        // Drain past empty; the head wraps around the store on the way.
        // Enough byte pops to empty a full store, then bit pops for the rest.
        repeat (CAPACITY_BITS / BYTE_BITS) send_op(MODE_POP_BYTE, DATA_W'($urandom()));
        repeat (BYTE_BITS + 1) send_op(MODE_POP_BIT, DATA_W'($urandom()));
        wait_for_results();

        // Closing stretch at full rate on both sides.
        quiet <= 1'b1;
        repeat (100) send_random_op();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d operations and checked %0d results, covering empty and full",
                 ops_sent, results_seen);
        $display("refusals, unused modes, index wrap-around and back-to-back transfers.");
        if (fail_count == 0) begin
            $display("msb_first_bit_fifo test passed");
        end else begin
            $display("msb_first_bit_fifo test failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/mfbf_pkg.sv
rtl/mfbf_ram.sv
rtl/mfbf_datapath.sv
rtl/mfbf_ctrl.sv
rtl/msb_first_bit_fifo.sv
tb/sv/msb_first_bit_fifo_checker.sv
tb/sv/msb_first_bit_fifo_test.sv
